// ----- sv/vr3_pkg.sv -----
`default_nettype none

package vr3_pkg;

  // component and arithmetic widths
  localparam int COMP_W  = 16;
  localparam int PROD_W  = 2 * COMP_W;          // one raw product
  localparam int DOT_W   = PROD_W + 2;          // signed sum of three products
  localparam int MAG_W   = PROD_W;              // |v.n| and n.n fit here
  localparam int Q_W     = PROD_W;              // divisor n.n
  localparam int NUM_W   = MAG_W + COMP_W + 1;  // 2 |v.n| |n_i|
  localparam int QUO_W   = COMP_W + 2;          // quotient is below 2 |v|
  localparam int REM_W   = Q_W;                 // partial remainder stays below q
  localparam int ACC_W   = REM_W + QUO_W;       // remainder and quotient shift word
  localparam int RES_W   = QUO_W + 2;           // v_i +/- term before clamping

  // divider pipeline shape
  localparam int BITS_PER_STG = 2;
  localparam int DIV_STAGES   = QUO_W / BITS_PER_STG;

  // pipeline stage positions
  localparam int STG_PROD   = 0;
  localparam int STG_SUM    = 1;
  localparam int STG_MUL    = 2;
  localparam int STG_DIV0   = 3;
  localparam int STG_RND    = STG_DIV0 + DIV_STAGES;
  localparam int STG_FIN    = STG_RND + 1;
  localparam int STG_OUT    = STG_FIN + 1;
  localparam int NUM_STAGES = STG_OUT + 1;

  localparam int NUM_AXES = 3;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    comp_t view_x;
    comp_t view_y;
    comp_t view_z;
    comp_t normal_x;
    comp_t normal_y;
    comp_t normal_z;
  } in_word_t;

  typedef struct packed {
    comp_t refl_x;
    comp_t refl_y;
    comp_t refl_z;
    logic  zero_normal;
    logic  saturated;
  } out_word_t;

  // per-stage load strobes from the flow control
  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
  } stg_en_t;

  // dot products after the sum stage
  typedef struct packed {
    comp_t [NUM_AXES-1:0] v;
    comp_t [NUM_AXES-1:0] n;
    logic                 dneg;
    logic [MAG_W-1:0]     dmag;
    logic [Q_W-1:0]       q;
  } dot_t;

  // what one lane takes in
  typedef struct packed {
    comp_t            v;
    comp_t            n;
    logic             dneg;
    logic [MAG_W-1:0] dmag;
    logic [Q_W-1:0]   q;
  } lane_in_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    comp_t r;
    logic  sat;
    comp_t v;
    logic  zero;
  } lane_out_t;

endpackage

`default_nettype wire

// ----- sv/vr3_dot.sv -----
`default_nettype none

module vr3_dot
  import vr3_pkg::*;
(
  input  wire logic                 clk,
  input  wire stg_en_t              en,
  input  wire comp_t [NUM_AXES-1:0] v_in,
  input  wire comp_t [NUM_AXES-1:0] n_in,
  output dot_t                      dot_o
);

  comp_t [NUM_AXES-1:0] v_r;
  comp_t [NUM_AXES-1:0] n_r;
  prod_t [NUM_AXES-1:0] pvn_r;
  prod_t [NUM_AXES-1:0] pnn_r;

  logic signed [DOT_W-1:0] dsum;
  logic signed [DOT_W-1:0] dabs;
  logic [Q_W-1:0]          qsum;
  dot_t                    dot_nxt;
  dot_t                    dot_r;

  // raw products v_i n_i and n_i n_i
  always_ff @(posedge clk) begin
    if (en.ld[STG_PROD]) begin
      v_r <= v_in;
      n_r <= n_in;
      for (int i = 0; i < NUM_AXES; i++) begin
        pvn_r[i] <= $signed(v_in[i]) * $signed(n_in[i]);
        pnn_r[i] <= $signed(n_in[i]) * $signed(n_in[i]);
      end
    end
  end

  // sums, sign and magnitude of v.n
  always_comb begin
    dsum = {{(DOT_W-PROD_W){pvn_r[0][PROD_W-1]}}, pvn_r[0]}
         + {{(DOT_W-PROD_W){pvn_r[1][PROD_W-1]}}, pvn_r[1]}
         + {{(DOT_W-PROD_W){pvn_r[2][PROD_W-1]}}, pvn_r[2]};
    qsum = Q_W'(pnn_r[0]) + Q_W'(pnn_r[1]) + Q_W'(pnn_r[2]);
    dabs = dsum[DOT_W-1] ? -dsum : dsum;
    dot_nxt.v    = v_r;
    dot_nxt.n    = n_r;
    dot_nxt.dneg = dsum[DOT_W-1];
    dot_nxt.dmag = dabs[MAG_W-1:0];
    dot_nxt.q    = qsum;
  end

  always_ff @(posedge clk) begin
    if (en.ld[STG_SUM]) begin
      dot_r <= dot_nxt;
    end
  end

  assign dot_o = dot_r;

endmodule

`default_nettype wire

// ----- sv/vr3_lane.sv -----
`default_nettype none

module vr3_lane
  import vr3_pkg::*;
(
  input  wire logic     clk,
  input  wire stg_en_t  en,
  input  wire lane_in_t lane_i,
  output lane_out_t     lane_o
);

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [Q_W-1:0]   q;
    comp_t            v;
    logic             tneg;
  } div_t;

  typedef struct packed {
    logic [QUO_W-1:0] t;
    logic             tneg;
    comp_t            v;
    logic             zero;
  } rnd_t;

  // restoring division steps, remainder in the upper bits, quotient shifts in below
  function automatic div_t div_steps(div_t d);
    div_t           s;
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;
    s = d;
    for (int b = 0; b < BITS_PER_STG; b++) begin
      trial = {s.acc[ACC_W-1:QUO_W], s.acc[QUO_W-1]};
      diff  = trial - {1'b0, s.q};
      ge    = (trial >= {1'b0, s.q});
      s.acc = {(ge ? diff[REM_W-1:0] : trial[REM_W-1:0]), s.acc[QUO_W-2:0], ge};
    end
    return s;
  endfunction

  logic [COMP_W-1:0]        nmag;
  logic [MAG_W+COMP_W-1:0]  nprod;
  logic [NUM_W-1:0]         num;
  div_t                     mul_nxt;
  div_t                     mul_r;
  div_t                     div_r [DIV_STAGES];
  rnd_t                     rnd_nxt;
  rnd_t                     rnd_r;
  logic [REM_W:0]           rem2;
  logic signed [RES_W-1:0]  vx;
  logic signed [RES_W-1:0]  tx;
  logic signed [RES_W-1:0]  rsum;
  logic [RES_W-COMP_W:0]    rhi;
  lane_out_t                fin_nxt;
  lane_out_t                fin_r;

  // numerator 2 |v.n| |n_i|
  always_comb begin
    nmag  = lane_i.n[COMP_W-1] ? COMP_W'(-lane_i.n) : COMP_W'(lane_i.n);
    nprod = lane_i.dmag * nmag;
    num   = {nprod, 1'b0};
    mul_nxt.acc  = ACC_W'(num);
    mul_nxt.q    = lane_i.q;
    mul_nxt.v    = lane_i.v;
    mul_nxt.tneg = lane_i.dneg ^ lane_i.n[COMP_W-1];
  end

  always_ff @(posedge clk) begin
    if (en.ld[STG_MUL]) begin
      mul_r <= mul_nxt;
    end
  end

  // divider stages
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (en.ld[STG_DIV0 + j]) begin
        if (j == 0) begin
          div_r[j] <= div_steps(mul_r);
        end else begin
          div_r[j] <= div_steps(div_r[(j == 0) ? 0 : j - 1]);
        end
      end
    end
  end : g_div

  // round half away from zero: bump when 2 rem >= q
  always_comb begin
    rem2 = {div_r[DIV_STAGES-1].acc[ACC_W-1:QUO_W], 1'b0};
    rnd_nxt.t    = div_r[DIV_STAGES-1].acc[QUO_W-1:0]
                 + QUO_W'(rem2 >= {1'b0, div_r[DIV_STAGES-1].q});
    rnd_nxt.tneg = div_r[DIV_STAGES-1].tneg;
    rnd_nxt.v    = div_r[DIV_STAGES-1].v;
    rnd_nxt.zero = (div_r[DIV_STAGES-1].q == '0);
  end

  always_ff @(posedge clk) begin
    if (en.ld[STG_RND]) begin
      rnd_r <= rnd_nxt;
    end
  end

  // apply the term and clamp to the component range
  always_comb begin
    vx   = {{(RES_W-COMP_W){rnd_r.v[COMP_W-1]}}, rnd_r.v};
    tx   = $signed({{(RES_W-QUO_W){1'b0}}, rnd_r.t});
    rsum = rnd_r.tneg ? vx + tx : vx - tx;
    rhi  = rsum[RES_W-1:COMP_W-1];
    fin_nxt.v    = rnd_r.v;
    fin_nxt.zero = rnd_r.zero;
    if ((&rhi) || !(|rhi)) begin
      fin_nxt.r   = rsum[COMP_W-1:0];
      fin_nxt.sat = 1'b0;
    end else begin
      fin_nxt.r   = rsum[RES_W-1] ? {1'b1, {(COMP_W-1){1'b0}}} : {1'b0, {(COMP_W-1){1'b1}}};
      fin_nxt.sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld[STG_FIN]) begin
      fin_r <= fin_nxt;
    end
  end

  assign lane_o = fin_r;

endmodule

`default_nettype wire

// ----- sv/vr3_merge.sv -----
`default_nettype none

module vr3_merge
  import vr3_pkg::*;
(
  input  wire logic                     clk,
  input  wire stg_en_t                  en,
  input  wire lane_out_t [NUM_AXES-1:0] lanes,
  output out_word_t                     word_o
);

  out_word_t word_nxt;
  out_word_t word_r;
  logic      zero;

  // zero normal passes the view through, otherwise gather the lanes
  always_comb begin
    zero = lanes[0].zero;
    word_nxt.refl_x      = zero ? lanes[0].v : lanes[0].r;
    word_nxt.refl_y      = zero ? lanes[1].v : lanes[1].r;
    word_nxt.refl_z      = zero ? lanes[2].v : lanes[2].r;
    word_nxt.zero_normal = zero;
    word_nxt.saturated   = !zero && (lanes[0].sat || lanes[1].sat || lanes[2].sat);
  end

  always_ff @(posedge clk) begin
    if (en.ld[STG_OUT]) begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;

endmodule

`default_nettype wire

// ----- sv/vector_reflect_3d.sv -----
// vector_reflect_3d: reflects a view vector about a surface normal,
// r = v - round(2 (v.n) n / (n.n)), on raw signed 16-bit components.
// in_valid/in_ready carry one input word (view and normal vectors),
// out_valid/out_ready carry one result word (reflected vector, a flag
// for a zero normal, which returns the view unchanged, and a flag for a
// component clamped to the signed range).
// Throughput: one word per clock while out_ready is high. The pipeline
// depth comes from the restoring divider, nine stages of two quotient
// bits each, behind the product, sum and lane multiply stages.
// The three axes run in their own lanes; a merge stage forms the flags.
// Each stage has a valid bit; when out_ready is low a stage only holds
// if the one after it is full, so bubbles close up and in_ready drops
// only once every stage holds a word.
// Reset (rst_n low, synchronous) clears all valid bits; no word is lost
// or repeated across a stall.
`default_nettype none

module vector_reflect_3d
  import vr3_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_word
);

  logic [NUM_STAGES-1:0]    valid_r;
  logic [NUM_STAGES-1:0]    valid_nxt;
  logic [NUM_STAGES-1:0]    free;
  stg_en_t                  en;
  comp_t [NUM_AXES-1:0]     v_in;
  comp_t [NUM_AXES-1:0]     n_in;
  dot_t                     dot;
  lane_in_t [NUM_AXES-1:0]  lane_in;
  lane_out_t [NUM_AXES-1:0] lane_out;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    free[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      free[k] = !valid_r[k] || free[k+1];
    end
    valid_nxt = (free & {valid_r[NUM_STAGES-2:0], in_valid}) | (~free & valid_r);
    en.ld     = free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = free[0];
  assign out_valid = valid_r[STG_OUT];

  // dot products
  assign v_in = {in_word.view_z, in_word.view_y, in_word.view_x};
  assign n_in = {in_word.normal_z, in_word.normal_y, in_word.normal_x};

  vr3_dot u_dot (
    .clk   (clk),
    .en    (en),
    .v_in  (v_in),
    .n_in  (n_in),
    .dot_o (dot)
  );

  // one lane per axis
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    always_comb begin
      lane_in[i].v    = dot.v[i];
      lane_in[i].n    = dot.n[i];
      lane_in[i].dneg = dot.dneg;
      lane_in[i].dmag = dot.dmag;
      lane_in[i].q    = dot.q;
    end

    vr3_lane u_lane (
      .clk    (clk),
      .en     (en),
      .lane_i (lane_in[i]),
      .lane_o (lane_out[i])
    );
  end : g_lane

  vr3_merge u_merge (
    .clk    (clk),
    .en     (en),
    .lanes  (lane_out),
    .word_o (out_word)
  );

  // words in flight change only by what is accepted and delivered
  a_occupancy : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones(valid_r) + int'($past(out_valid && out_ready))
       == $past($countones(valid_r)) + int'($past(in_valid && in_ready))))
    else $error("pipeline occupancy does not match the handshakes");

  // input is held off only when the whole pipeline is full and stalled
  a_ready_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> ((&valid_r) && !out_ready))
    else $error("input stalled while a stage was free");

  // a zero normal never reports saturation
  a_zero_nosat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.zero_normal && out_word.saturated))
    else $error("zero normal result flagged as saturated");

endmodule

`default_nettype wire
